>>> sv/modular_exponentiation_prime_unit_defines.svh
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_PRIME_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_PRIME_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MEXP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mexp_pkg.sv
// Package with the constants and sequencer types of the modular exponentiation unit.
package mexp_pkg;

    // Prime modulus and its multiples, used by the final correction and its bound check.
    localparam logic [29:0] PRIME_MOD     = 30'd1000000007;
    localparam logic [31:0] PRIME_MOD_X1  = 32'd1000000007;
    localparam logic [31:0] PRIME_MOD_X2  = 32'd2000000014;
    localparam logic [31:0] PRIME_MOD_X3  = 32'd3000000021;

    // Barrett constant: floor(2^60 / PRIME_MOD).
    localparam logic [30:0] BARRETT_MU    = 31'd1152921496;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EST,
        S_REM,
        S_FIX,
        S_DONE
    } mexp_state_t;

    typedef enum logic {
        OP_ACC,
        OP_SQR
    } mexp_op_t;

endpackage

>>> sv/modular_exponentiation_prime_unit.sv
// Top level of the modular exponentiation unit: base to the exponent modulo 1000000007.
//
// Usage: a request on the input channel (in_valid/in_ready) carries base_value and
// exponent; one result, power_result, leaves on the output channel (out_valid/out_ready).
// The unit scans the exponent from bit 0 upward (right-to-left square and multiply).
// Every modular product runs on a single shared 32x32 multiplier in four steps: the
// raw product, a Barrett quotient estimate, the remainder, and a final correction.
// Per request the sequencer runs one multiply per set exponent bit and one square per
// bit below the highest set bit; a zero exponent gives the result 1 with no product.
// One request is processed at a time: in_ready is high only while the sequencer is
// idle, which it enters in the cycle after the result is loaded.
// The finished result sits in an output register, so a new request can be accepted
// while the receiver stalls; the sequencer only waits if a second result is ready
// before the first was taken.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and drops
// out_valid; no result survives it.
`include "modular_exponentiation_prime_unit_defines.svh"

module modular_exponentiation_prime_unit
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [29:0] base_value,
    input  logic [31:0] exponent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [29:0] power_result
);

    // Exponent bits actually scanned: EXP_BITS, capped by the 32-bit field.
    localparam int EW = (EXP_BITS < 32) ? EXP_BITS : 32;

    mexp_state_t   state_reg;
    mexp_state_t   state_next;
    mexp_op_t      op_reg;

    logic [EW-1:0] exp_reg;
    logic [29:0]   acc_reg;       // running result
    logic [29:0]   sq_reg;        // running power of the base
    logic [59:0]   prod_reg;      // raw product of the current modular multiply
    logic [30:0]   q_reg;         // Barrett quotient estimate
    logic [31:0]   rem_reg;       // remainder before correction, below three moduli
    logic [29:0]   out_data_reg;
    logic          out_valid_reg;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_out;
    logic [29:0]   base_red;
    logic [29:0]   rem_fixed;
    logic          exp_is_zero;
    logic          exp_upper_zero;
    logic          out_free;
    logic          done_load;

    // The base may arrive up to 2^30 - 1, which is below twice the modulus.
    assign base_red       = (base_value >= PRIME_MOD) ? (base_value - PRIME_MOD) : base_value;
    assign exp_is_zero    = (exponent[EW-1:0] == '0);
    assign exp_upper_zero = (exp_reg[EW-1:1] == '0);
    assign out_free       = !out_valid_reg || out_ready;

    // The one shared multiplier.
    assign mul_out = mul_a * mul_b;

    // Final correction: the Barrett estimate is at most two below the true quotient.
    always_comb
    begin
        if (rem_reg >= PRIME_MOD_X2)
        begin
            rem_fixed = 30'(rem_reg - PRIME_MOD_X2);
        end
        else if (rem_reg >= PRIME_MOD_X1)
        begin
            rem_fixed = 30'(rem_reg - PRIME_MOD_X1);
        end
        else
        begin
            rem_fixed = rem_reg[29:0];
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = exp_is_zero ? S_DONE : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_EST;
            end
            S_EST:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                // After the last multiply into the accumulator no more squares matter.
                if (op_reg == OP_ACC && exp_upper_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and datapath control of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        done_load = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_MUL:
            begin
                mul_a = {2'b00, (op_reg == OP_ACC) ? acc_reg : sq_reg};
                mul_b = {2'b00, sq_reg};
            end
            S_EST:
            begin
                mul_a = {1'b0, prod_reg[59:29]};
                mul_b = {1'b0, BARRETT_MU};
            end
            S_REM:
            begin
                mul_a = {1'b0, q_reg};
                mul_b = {2'b00, PRIME_MOD};
            end
            S_FIX:
            begin
            end
            S_DONE:
            begin
                done_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SQR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in_valid)
            begin
                op_reg <= exponent[0] ? OP_ACC : OP_SQR;
            end
            else if (state_reg == S_FIX)
            begin
                if (op_reg == OP_ACC)
                begin
                    op_reg <= OP_SQR;
                end
                else
                begin
                    op_reg <= exp_reg[1] ? OP_ACC : OP_SQR;
                end
            end
            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    exp_reg <= exponent[EW-1:0];
                    acc_reg <= 30'd1;
                    sq_reg  <= base_red;
                end
            end
            S_MUL:
            begin
                prod_reg <= mul_out[59:0];
            end
            S_EST:
            begin
                q_reg <= mul_out[61:31];
            end
            S_REM:
            begin
                rem_reg <= prod_reg[31:0] - mul_out[31:0];
            end
            S_FIX:
            begin
                if (op_reg == OP_ACC)
                begin
                    acc_reg <= rem_fixed;
                end
                else
                begin
                    sq_reg  <= rem_fixed;
                    exp_reg <= exp_reg >> 1;
                end
            end
            S_DONE:
            begin
                if (done_load)
                begin
                    out_data_reg <= acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

    // Every delivered result is fully reduced.
    `MEXP_ASSERT_IMP(a_result_reduced, out_valid, power_result < PRIME_MOD,
        "power_result not below the modulus")

    // The Barrett remainder never needs more than two corrections.
    `MEXP_ASSERT_IMP(a_rem_bound, state_reg == S_FIX, rem_reg < PRIME_MOD_X3,
        "remainder exceeds three moduli")

    // Operands of each modular product are reduced.
    `MEXP_ASSERT_IMP(a_operands_reduced, state_reg == S_MUL,
        acc_reg < PRIME_MOD && sq_reg < PRIME_MOD, "multiplier operand not reduced")

    // While products run, exponent bits remain to be processed.
    `MEXP_ASSERT_IMP(a_exp_live, state_reg == S_MUL || state_reg == S_FIX,
        exp_reg != '0, "exponent exhausted during a product")

endmodule

>>> tb/testbench.sv
// Testbench for the modular exponentiation unit: self-checking power mod 1000000007.
`timescale 1ns / 100ps

module testbench;

    // The exponent width that the unit scans; the prediction masks the same bits.
    localparam int EXP_SCAN = 32;

    // The prime modulus, wide enough that a product of two residues never overflows.
    localparam logic [63:0] MODULUS    = 64'd1000000007;
    localparam logic [31:0] PRIME_WORD = 32'd1000000007;
    localparam logic [29:0] BASE_MAX   = 30'h3FFF_FFFF;
    localparam logic [31:0] EXP_MAX    = 32'hFFFF_FFFF;

    // Total request count, directed part included.
    localparam int REQUEST_COUNT = 1550;

    // Even with the slowest request, the longest sender gap and the longest receiver
    // stall on top of it, a correct run stays far below this.
    localparam int CYCLE_LIMIT = 3000000;

    // Extra cycles after the last result, enough for one full-length request.
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [29:0] base;
        logic [31:0] power;
    } power_request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [29:0] base_value;
    logic [31:0] exponent;
    logic        out_valid;
    logic        out_ready;
    logic [29:0] power_result;

    // Requests waiting to be sent, and the results the unit still owes us.
    power_request_t pending_requests[$];
    logic [29:0]    expected_powers[$];

    int             fail_count;
    int             cycle_count;
    int             sender_gap_left;
    int             receiver_stall_left;
    bit             sender_dense;
    bit             receiver_dense;
    power_request_t next_request;
    logic [29:0]    wanted_power;

    modular_exponentiation_prime_unit #(
        .EXP_BITS (EXP_SCAN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result)
    );

    // Right-to-left square and multiply. The base is reduced first, so bases at or
    // above the prime give the same result as their residue.
    function automatic logic [29:0] predict_power(input logic [29:0] base_in,
                                                  input logic [31:0] exp_in);
        logic [63:0] running_square;
        logic [63:0] accumulator;
        running_square = {34'd0, base_in} % MODULUS;
        accumulator    = 64'd1;
        for (int i = 0; i < EXP_SCAN && i < 32; i++)
        begin
            if (exp_in[i])
                accumulator = (accumulator * running_square) % MODULUS;
            running_square = (running_square * running_square) % MODULUS;
        end
        return accumulator[29:0];
    endfunction

    // Idle lengths: mostly none or a few cycles, now and then a long pause. A dense
    // stretch switches idling off altogether for a while.
    function automatic int idle_length(input bit dense);
        int pick;
        pick = $urandom_range(0, 99);
        if (dense || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [29:0] random_base();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 30'($urandom_range(0, 1000000006));
        else if (pick < 50)
            return 30'($urandom_range(1000000007, 32'h3FFF_FFFF));
        else if (pick < 65)
            return 30'($urandom_range(0, 15));
        else if (pick < 75)
            return PRIME_WORD[29:0] - 30'($urandom_range(1, 16));
        else
            return 30'($urandom());
    endfunction

    function automatic logic [31:0] random_exponent();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return $urandom();
        else if (pick < 50)
            return $urandom_range(0, 64);
        else if (pick < 65)
            return $urandom() >> $urandom_range(0, 31);
        else if (pick < 75)
            return PRIME_WORD - 32'd2;
        else if (pick < 80)
            return 32'd0;
        else if (pick < 90)
            return 32'd1 << $urandom_range(0, 31);
        else
            return $urandom() & $urandom() & $urandom();
    endfunction

    task automatic queue_request(input logic [29:0] base_in, input logic [31:0] exp_in);
        power_request_t req;
        req.base  = base_in;
        req.power = exp_in;
        pending_requests = {pending_requests, req};
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sender. A request stays on the port until it is taken; the prediction for it
    // is queued at the very edge where the handshake completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            base_value      <= '0;
            exponent        <= '0;
            sender_gap_left = 0;
            sender_dense    = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_powers = {expected_powers, predict_power(base_value, exponent)};
            if (!in_valid || in_ready)
            begin
                if (sender_gap_left > 0)
                begin
                    sender_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_request = pending_requests.pop_front();
                    in_valid     <= 1'b1;
                    base_value   <= next_request.base;
                    exponent     <= next_request.power;
                    if ($urandom_range(0, 149) == 0)
                        sender_dense = !sender_dense;
                    sender_gap_left = idle_length(sender_dense);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every result taken is checked against the oldest prediction, and
    // out_ready is pulled low for random stretches to back-pressure the unit.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready           <= 1'b0;
            receiver_stall_left = 0;
            receiver_dense      = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: expected none outstanding, actual %0d",
                           power_result);
                    fail_count++;
                end
                else
                begin
                    wanted_power = expected_powers.pop_front();
                    if (power_result !== wanted_power)
                    begin
                        $error("power_result: expected %0d, actual %0d",
                               wanted_power, power_result);
                        fail_count++;
                    end
                end
            end
            if (receiver_stall_left > 0)
            begin
                receiver_stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 149) == 0)
                    receiver_dense = !receiver_dense;
                receiver_stall_left = idle_length(receiver_dense);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;

        // Directed requests: zero exponent (also with a zero base), zero base with a
        // nonzero exponent, the Fermat inverse, bases at or above the prime, and the
        // extremes of both fields.
        queue_request(30'd0, 32'd0);
        queue_request(30'd0, 32'd1);
        queue_request(30'd0, EXP_MAX);
        queue_request(30'd1, EXP_MAX);
        queue_request(30'd2, 32'd0);
        queue_request(30'd2, 32'd1);
        queue_request(30'd2, 32'd30);
        queue_request(30'd2, 32'd31);
        queue_request(30'd2, PRIME_WORD - 32'd2);
        queue_request(30'd123456789, PRIME_WORD - 32'd2);
        queue_request(PRIME_WORD[29:0] - 30'd1, PRIME_WORD - 32'd2);
        queue_request(PRIME_WORD[29:0] - 30'd1, EXP_MAX);
        queue_request(PRIME_WORD[29:0] - 30'd1, 32'd2);
        queue_request(PRIME_WORD[29:0], 32'd5);
        queue_request(PRIME_WORD[29:0], 32'd0);
        queue_request(PRIME_WORD[29:0] + 30'd1, EXP_MAX);
        queue_request(BASE_MAX, 32'd1);
        queue_request(BASE_MAX, EXP_MAX);
        queue_request(30'h1555_5555, 32'h8000_0000);
        queue_request(30'h2AAA_AAAA, 32'h5555_5555);
        queue_request(30'd3, 32'hAAAA_AAAA);

        while (pending_requests.size() < REQUEST_COUNT)
            queue_request(random_base(), random_exponent());

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Every request handed over, then every result back, then a quiet tail in
        // which a stray extra result would still be caught.
        while (pending_requests.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_powers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_powers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
